// ----- sv/mfba_pkg.sv -----
`timescale 1ns / 1ps
// mfba_pkg: shared codes and types for the max-flow core.
// No dependencies; used by every file under sv/ but mfba_arc_mem.
package mfba_pkg;

   localparam int NODE_W   = 9;
   localparam int FCAP_W   = 24;
   localparam int FLOW_W   = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_SAT   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINK   = 1'd1;

   typedef struct packed {
      logic first;
      logic visited;
      logic parent;
      logic queue;
   } node_we_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLR, ST_ADD_WR1, ST_ADD_RD2, ST_ADD_WR2,
      ST_VCLR, ST_START, ST_PUSH0, ST_POP, ST_POPW, ST_FIRSTW,
      ST_ARC, ST_ARCW, ST_CHK, ST_PUSH,
      ST_B_PAR, ST_B_ARC, ST_B_REV, ST_B_HEAD,
      ST_U_PAR, ST_U_ARC, ST_U_WR, ST_U_REV, ST_U_WRREV,
      ST_ACC, ST_RUN_DONE, ST_RESP
   } state_type;

endpackage

// ----- sv/mfba_ifs.sv -----
`timescale 1ns / 1ps
// mfba_req_if / mfba_rsp_if: valid-ready channels of the max-flow core.
// Depends on mfba_pkg for field widths.
interface mfba_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [mfba_pkg::NODE_W-1:0]   from_node;
   logic [mfba_pkg::NODE_W-1:0]   to_node;
   logic [mfba_pkg::FCAP_W-1:0]   forward_capacity;
   logic [mfba_pkg::FCAP_W-1:0]   reverse_capacity;
   modport source (output valid, command, from_node, to_node, forward_capacity,
                   reverse_capacity, input ready);
   modport sink   (input valid, command, from_node, to_node, forward_capacity,
                   reverse_capacity, output ready);
endinterface

interface mfba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [mfba_pkg::FLOW_W-1:0]   total_flow;
   modport source (output valid, status, total_flow, input ready);
   modport sink   (input valid, status, total_flow, output ready);
endinterface

// ----- sv/mfba_arc_mem.sv -----
`timescale 1ns / 1ps
// mfba_arc_mem: single-port arc table (head, capacity, flow, next arc).
// Registered read. Depends on nothing.
module mfba_arc_mem #(
   parameter int AW  = 14,
   parameter int CAP = 24,
   parameter int FW  = 26,
   parameter int CW  = 15
) (
   input  logic                 clock,
   input  logic [AW-1:0]        addr,
   input  logic                 we,
   input  logic [8:0]           whead,
   input  logic [CAP-1:0]       wcap,
   input  logic signed [FW-1:0] wflow,
   input  logic [CW-1:0]        wnext,
   output logic [8:0]           rhead,
   output logic [CAP-1:0]       rcap,
   output logic signed [FW-1:0] rflow,
   output logic [CW-1:0]        rnext
);
   localparam int DEPTH = 1 << AW;

   logic [8:0]           head_mem [DEPTH];
   logic [CAP-1:0]       cap_mem  [DEPTH];
   logic signed [FW-1:0] flow_mem [DEPTH];
   logic [CW-1:0]        next_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         head_mem[addr] <= whead;
         cap_mem[addr]  <= wcap;
         flow_mem[addr] <= wflow;
         next_mem[addr] <= wnext;
      end
      rhead <= head_mem[addr];
      rcap  <= cap_mem[addr];
      rflow <= flow_mem[addr];
      rnext <= next_mem[addr];
   end
endmodule

// ----- sv/mfba_node_mem.sv -----
`timescale 1ns / 1ps
// mfba_node_mem: single-port node table (first arc, visited, parent, queue slot)
// with per-field write enables. Depends on mfba_pkg.
module mfba_node_mem #(
   parameter int NW = 9,
   parameter int AW = 14,
   parameter int CW = 15
) (
   input  logic                  clock,
   input  logic [NW-1:0]         addr,
   input  mfba_pkg::node_we_type we,
   input  logic [CW-1:0]         wfirst,
   input  logic                  wvisited,
   input  logic [AW-1:0]         wparent,
   input  logic [8:0]            wqueue,
   output logic [CW-1:0]         rfirst,
   output logic                  rvisited,
   output logic [AW-1:0]         rparent,
   output logic [8:0]            rqueue
);
   localparam int DEPTH = 1 << NW;

   logic [CW-1:0] first_mem   [DEPTH];
   logic          visited_mem [DEPTH];
   logic [AW-1:0] parent_mem  [DEPTH];
   logic [8:0]    queue_mem   [DEPTH];

   always_ff @(posedge clock) begin
      if (we.first)   first_mem[addr]   <= wfirst;
      if (we.visited) visited_mem[addr] <= wvisited;
      if (we.parent)  parent_mem[addr]  <= wparent;
      if (we.queue)   queue_mem[addr]   <= wqueue;
      rfirst   <= first_mem[addr];
      rvisited <= visited_mem[addr];
      rparent  <= parent_mem[addr];
      rqueue   <= queue_mem[addr];
   end
endmodule

// ----- sv/max_flow_bfs_augment_core.sv -----
`timescale 1ns / 1ps
// max_flow_bfs_augment_core: Edmonds-Karp max-flow sequencer over arc and node tables.
// Depends on mfba_pkg, mfba_ifs, mfba_arc_mem, mfba_node_mem.
//
//   channel   dir   transaction
//   req_bus   in    command, from_node, to_node, forward_capacity, reverse_capacity
//   rsp_bus   out   status, total_flow (one per request)
//   csr_*     in    write of source_node (0) / sink_node (1)
//
// Add: accept, then ST_ADD_WR1, ST_ADD_RD2 and ST_ADD_WR2 on the tables, then load the result.
// Clear: a node-table sweep plus accept and result. Run: per search a visited sweep, queue
// seeding, then pop steps and arc-scan steps (with a push when an arc's head is queued), then
// bottleneck and update walks per path hop; one node-memory port bounds it.
// After reset a node-table sweep empties the node lists; req_bus.ready stays low meanwhile.
// A request is taken while the previous result still waits on rsp_bus.
module max_flow_bfs_augment_core #(
   parameter int MAX_NODES = 512,
   parameter int MAX_ARCS  = 16384,
   parameter int CAP_BITS  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   mfba_req_if.sink                          req_bus,
   mfba_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [mfba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mfba_pkg::NODE_W-1:0]       csr_wdata
);
   localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int AW = $clog2(MAX_ARCS);
   localparam int CW = $clog2(MAX_ARCS + 1);
   localparam int FW = CAP_BITS + 2;
   localparam int SW = ((FW > 32) ? FW : 32) + 1;
   localparam logic [CW-1:0] EMPTY = CW'(MAX_ARCS);
   localparam logic [NW:0]   LAST_NODE = (NW + 1)'(MAX_NODES - 1);
   localparam logic signed [FW-1:0] BEST_MAX = {1'b0, {(FW-1){1'b1}}};

   mfba_pkg::state_type state_ff, state_in;
   logic [NW:0]    idx_ff, idx_in, qh_ff, qh_in, qt_ff, qt_in;
   logic [CW-1:0]  arc_ff, arc_in, next_ff, next_in, count_ff, count_in;
   logic [8:0]     node_ff, node_in, from_ff, from_in, to_ff, to_in;
   logic [8:0]     src_ff, sink_ff;
   logic [CAP_BITS-1:0] fcap_ff, fcap_in, rcap_ff, rcap_in;
   logic [AW-1:0]  par_ff, par_in;
   logic signed [FW-1:0] res_ff, res_in, best_ff, best_in;
   logic [31:0]    acc_ff, acc_in, flow_res_ff, flow_res_in;
   logic           sat_ff, sat_in, clr_resp_ff, clr_resp_in;
   logic [1:0]     st_ff, st_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_flow_ff, rsp_flow_in;

   logic [AW-1:0]        arc_addr;
   logic                 arc_we;
   logic [8:0]           arc_whead, arc_rhead;
   logic [CAP_BITS-1:0]  arc_wcap, arc_rcap;
   logic signed [FW-1:0] arc_wflow, arc_rflow, arc_res;
   logic [CW-1:0]        arc_wnext, arc_rnext;

   logic [NW-1:0]         node_addr;
   mfba_pkg::node_we_type node_we;
   logic [CW-1:0]         node_wfirst, node_rfirst;
   logic                  node_wvisited, node_rvisited;
   logic [AW-1:0]         node_wparent, node_rparent;
   logic [8:0]            node_wqueue, node_rqueue;
   logic [SW-1:0]         sum;

   mfba_arc_mem #(.AW(AW), .CAP(CAP_BITS), .FW(FW), .CW(CW)) u_arc_mem (
      .clock(clock), .addr(arc_addr), .we(arc_we),
      .whead(arc_whead), .wcap(arc_wcap), .wflow(arc_wflow), .wnext(arc_wnext),
      .rhead(arc_rhead), .rcap(arc_rcap), .rflow(arc_rflow), .rnext(arc_rnext));

   mfba_node_mem #(.NW(NW), .AW(AW), .CW(CW)) u_node_mem (
      .clock(clock), .addr(node_addr), .we(node_we),
      .wfirst(node_wfirst), .wvisited(node_wvisited), .wparent(node_wparent),
      .wqueue(node_wqueue), .rfirst(node_rfirst), .rvisited(node_rvisited),
      .rparent(node_rparent), .rqueue(node_rqueue));

   assign arc_res = $signed({2'b00, arc_rcap}) - arc_rflow;
   assign sum     = SW'(acc_ff) + SW'($unsigned(best_ff));

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.total_flow = rsp_flow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff  <= 9'd1;
         sink_ff <= 9'd2;
      end else if (csr_wr_en) begin
         case (csr_index)
            mfba_pkg::CSR_SOURCE: src_ff  <= csr_wdata;
            mfba_pkg::CSR_SINK:   sink_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfba_pkg::ST_CLR;
         idx_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_resp_ff  <= clr_resp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qh_ff <= qh_in;  qt_ff <= qt_in;  arc_ff <= arc_in;  next_ff <= next_in;
      node_ff <= node_in;  from_ff <= from_in;  to_ff <= to_in;
      fcap_ff <= fcap_in;  rcap_ff <= rcap_in;  par_ff <= par_in;
      res_ff <= res_in;  best_ff <= best_in;  acc_ff <= acc_in;  sat_ff <= sat_in;
      flow_res_ff <= flow_res_in;  st_ff <= st_in;
      rsp_status_ff <= rsp_status_in;  rsp_flow_ff <= rsp_flow_in;
   end

   always_comb begin
      state_in = state_ff;  idx_in = idx_ff;  qh_in = qh_ff;  qt_in = qt_ff;
      arc_in = arc_ff;  next_in = next_ff;  count_in = count_ff;  node_in = node_ff;
      from_in = from_ff;  to_in = to_ff;  fcap_in = fcap_ff;  rcap_in = rcap_ff;
      par_in = par_ff;  res_in = res_ff;  best_in = best_ff;  acc_in = acc_ff;
      sat_in = sat_ff;  flow_res_in = flow_res_ff;  st_in = st_ff;
      clr_resp_in = clr_resp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_status_in = rsp_status_ff;  rsp_flow_in = rsp_flow_ff;
      req_bus.ready = 1'b0;
      arc_addr = '0;  arc_we = 1'b0;  arc_whead = '0;  arc_wcap = '0;
      arc_wflow = '0;  arc_wnext = '0;
      node_addr = '0;  node_we = '0;  node_wfirst = '0;  node_wvisited = 1'b0;
      node_wparent = '0;  node_wqueue = '0;

      case (state_ff)
         mfba_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            from_in = req_bus.from_node;
            to_in   = req_bus.to_node;
            fcap_in = CAP_BITS'(req_bus.forward_capacity);
            rcap_in = CAP_BITS'(req_bus.reverse_capacity);
            node_addr = NW'(req_bus.from_node);
            flow_res_in = '0;
            st_in = mfba_pkg::STAT_OK;
            if (req_bus.valid) begin
               case (req_bus.command)
                  mfba_pkg::CMD_CLEAR: begin
                     idx_in = '0;
                     clr_resp_in = 1'b1;
                     state_in = mfba_pkg::ST_CLR;
                  end
                  mfba_pkg::CMD_ADD: begin
                     if (32'(req_bus.from_node) >= MAX_NODES ||
                         32'(req_bus.to_node) >= MAX_NODES) begin
                        st_in = mfba_pkg::STAT_RANGE;
                        state_in = mfba_pkg::ST_RESP;
                     end else if (32'(count_ff) + 32'd2 > MAX_ARCS) begin
                        st_in = mfba_pkg::STAT_FULL;
                        state_in = mfba_pkg::ST_RESP;
                     end else begin
                        state_in = mfba_pkg::ST_ADD_WR1;
                     end
                  end
                  mfba_pkg::CMD_RUN: begin
                     if (32'(src_ff) >= MAX_NODES || 32'(sink_ff) >= MAX_NODES) begin
                        st_in = mfba_pkg::STAT_RANGE;
                        state_in = mfba_pkg::ST_RESP;
                     end else begin
                        acc_in = '0;
                        sat_in = 1'b0;
                        idx_in = '0;
                        state_in = mfba_pkg::ST_VCLR;
                     end
                  end
                  default: state_in = mfba_pkg::ST_RESP;
               endcase
            end
         end
         mfba_pkg::ST_CLR: begin
            node_addr = idx_ff[NW-1:0];
            node_we.first = 1'b1;
            node_wfirst = EMPTY;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_NODE) begin
               count_in = '0;
               state_in = clr_resp_ff ? mfba_pkg::ST_RESP : mfba_pkg::ST_IDLE;
            end
         end
         mfba_pkg::ST_ADD_WR1: begin
            arc_addr = count_ff[AW-1:0];
            arc_we = 1'b1;
            arc_whead = to_ff;
            arc_wcap = fcap_ff;
            arc_wnext = node_rfirst;
            node_addr = NW'(from_ff);
            node_we.first = 1'b1;
            node_wfirst = count_ff;
            state_in = mfba_pkg::ST_ADD_RD2;
         end
         mfba_pkg::ST_ADD_RD2: begin
            node_addr = NW'(to_ff);
            state_in = mfba_pkg::ST_ADD_WR2;
         end
         mfba_pkg::ST_ADD_WR2: begin
            arc_addr = AW'(count_ff + 1'b1);
            arc_we = 1'b1;
            arc_whead = from_ff;
            arc_wcap = rcap_ff;
            arc_wnext = node_rfirst;
            node_addr = NW'(to_ff);
            node_we.first = 1'b1;
            node_wfirst = count_ff + 1'b1;
            count_in = count_ff + CW'(2);
            state_in = mfba_pkg::ST_RESP;
         end
         mfba_pkg::ST_VCLR: begin
            node_addr = idx_ff[NW-1:0];
            node_we.visited = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_NODE) state_in = mfba_pkg::ST_START;
         end
         mfba_pkg::ST_START: begin
            node_addr = NW'(src_ff);
            node_we.visited = 1'b1;
            node_wvisited = 1'b1;
            state_in = mfba_pkg::ST_PUSH0;
         end
         mfba_pkg::ST_PUSH0: begin
            node_addr = '0;
            node_we.queue = 1'b1;
            node_wqueue = src_ff;
            qh_in = '0;
            qt_in = (NW + 1)'(1);
            state_in = mfba_pkg::ST_POP;
         end
         mfba_pkg::ST_POP: begin
            node_addr = qh_ff[NW-1:0];
            if (qh_ff == qt_ff) begin
               state_in = mfba_pkg::ST_RUN_DONE;
            end else begin
               qh_in = qh_ff + 1'b1;
               state_in = mfba_pkg::ST_POPW;
            end
         end
         mfba_pkg::ST_POPW: begin
            node_in = node_rqueue;
            node_addr = NW'(node_rqueue);
            if (node_rqueue == sink_ff) begin
               best_in = BEST_MAX;
               state_in = (src_ff == sink_ff) ? mfba_pkg::ST_RUN_DONE : mfba_pkg::ST_B_PAR;
            end else begin
               state_in = mfba_pkg::ST_FIRSTW;
            end
         end
         mfba_pkg::ST_FIRSTW: begin
            arc_in = node_rfirst;
            state_in = mfba_pkg::ST_ARC;
         end
         mfba_pkg::ST_ARC: begin
            arc_addr = arc_ff[AW-1:0];
            state_in = (arc_ff >= count_ff) ? mfba_pkg::ST_POP : mfba_pkg::ST_ARCW;
         end
         mfba_pkg::ST_ARCW: begin
            node_in = arc_rhead;
            next_in = arc_rnext;
            res_in = arc_res;
            node_addr = NW'(arc_rhead);
            state_in = mfba_pkg::ST_CHK;
         end
         mfba_pkg::ST_CHK: begin
            if (!node_rvisited && !res_ff[FW-1] && res_ff != '0) begin
               node_addr = NW'(node_ff);
               node_we.visited = 1'b1;
               node_we.parent = 1'b1;
               node_wvisited = 1'b1;
               node_wparent = arc_ff[AW-1:0];
               state_in = mfba_pkg::ST_PUSH;
            end else begin
               arc_in = next_ff;
               state_in = mfba_pkg::ST_ARC;
            end
         end
         mfba_pkg::ST_PUSH: begin
            node_addr = qt_ff[NW-1:0];
            node_we.queue = 1'b1;
            node_wqueue = node_ff;
            qt_in = qt_ff + 1'b1;
            arc_in = next_ff;
            state_in = mfba_pkg::ST_ARC;
         end
         mfba_pkg::ST_B_PAR: begin
            node_addr = NW'(node_ff);
            if (node_ff == src_ff) begin
               node_in = sink_ff;
               state_in = mfba_pkg::ST_U_PAR;
            end else begin
               state_in = mfba_pkg::ST_B_ARC;
            end
         end
         mfba_pkg::ST_B_ARC: begin
            par_in = node_rparent;
            arc_addr = node_rparent;
            state_in = mfba_pkg::ST_B_REV;
         end
         mfba_pkg::ST_B_REV: begin
            if (arc_res < best_ff) best_in = arc_res;
            arc_addr = {par_ff[AW-1:1], ~par_ff[0]};
            state_in = mfba_pkg::ST_B_HEAD;
         end
         mfba_pkg::ST_B_HEAD: begin
            node_in = arc_rhead;
            state_in = mfba_pkg::ST_B_PAR;
         end
         mfba_pkg::ST_U_PAR: begin
            node_addr = NW'(node_ff);
            state_in = (node_ff == src_ff) ? mfba_pkg::ST_ACC : mfba_pkg::ST_U_ARC;
         end
         mfba_pkg::ST_U_ARC: begin
            par_in = node_rparent;
            arc_addr = node_rparent;
            state_in = mfba_pkg::ST_U_WR;
         end
         mfba_pkg::ST_U_WR: begin
            arc_addr = par_ff;
            arc_we = 1'b1;
            arc_whead = arc_rhead;
            arc_wcap = arc_rcap;
            arc_wflow = arc_rflow + best_ff;
            arc_wnext = arc_rnext;
            state_in = mfba_pkg::ST_U_REV;
         end
         mfba_pkg::ST_U_REV: begin
            arc_addr = {par_ff[AW-1:1], ~par_ff[0]};
            state_in = mfba_pkg::ST_U_WRREV;
         end
         mfba_pkg::ST_U_WRREV: begin
            arc_addr = {par_ff[AW-1:1], ~par_ff[0]};
            arc_we = 1'b1;
            arc_whead = arc_rhead;
            arc_wcap = arc_rcap;
            arc_wflow = arc_rflow - best_ff;
            arc_wnext = arc_rnext;
            node_in = arc_rhead;
            state_in = mfba_pkg::ST_U_PAR;
         end
         mfba_pkg::ST_ACC: begin
            acc_in = sum[31:0];
            if (sum[SW-1:32] != '0) sat_in = 1'b1;
            idx_in = '0;
            state_in = mfba_pkg::ST_VCLR;
         end
         mfba_pkg::ST_RUN_DONE: begin
            st_in = sat_ff ? mfba_pkg::STAT_SAT : mfba_pkg::STAT_OK;
            flow_res_in = sat_ff ? 32'hFFFF_FFFF : acc_ff;
            state_in = mfba_pkg::ST_RESP;
         end
         mfba_pkg::ST_RESP: begin
            clr_resp_in = 1'b0;
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = st_ff;
               rsp_flow_in = flow_res_ff;
               state_in = mfba_pkg::ST_IDLE;
            end
         end
         default: state_in = mfba_pkg::ST_IDLE;
      endcase
   end
endmodule

// ----- sv/mfba_checker.sv -----
`timescale 1ns / 1ps
// mfba_checker: port-level checks for max_flow_bfs_augment_core, plus its bind.
// Depends on mfba_pkg.
module mfba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_flow
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_flow))
      else $error("rsp dropped or changed while stalled");

   a_sat_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mfba_pkg::STAT_SAT |-> rsp_flow == 32'hFFFF_FFFF)
      else $error("saturated status without saturated flow");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == mfba_pkg::STAT_FULL ||
                    rsp_status == mfba_pkg::STAT_RANGE) |-> rsp_flow == '0)
      else $error("error status with nonzero flow");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("activity right after reset");
endmodule

bind max_flow_bfs_augment_core mfba_checker u_mfba_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_status(rsp_bus.status),
   .rsp_flow(rsp_bus.total_flow)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for max_flow_bfs_augment_core (Edmonds-Karp max flow).
// Depends on mfba_pkg, mfba_ifs and the core; predicts every response in SystemVerilog.
module testbench;

   localparam int NODES      = 512;
   localparam int ARCS       = 16384;
   localparam int NO_ARC     = ARCS;
   localparam int CYCLE_MAX  = 5000000;
   localparam int LONG_HOLD  = 3000;
   localparam logic [mfba_pkg::FCAP_W-1:0] CAP_MAX = 24'hFFFFFF;

   typedef struct {
      logic [1:0]                  command;
      logic [mfba_pkg::NODE_W-1:0] from_node;
      logic [mfba_pkg::NODE_W-1:0] to_node;
      logic [mfba_pkg::FCAP_W-1:0] fwd_cap;
      logic [mfba_pkg::FCAP_W-1:0] rev_cap;
   } flow_req_type;

   typedef struct {
      logic [1:0]                  status;
      logic [mfba_pkg::FLOW_W-1:0] total_flow;
   } flow_rsp_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [mfba_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mfba_pkg::NODE_W-1:0] csr_wdata;

   mfba_req_if req_bus ();
   mfba_rsp_if rsp_bus ();

   max_flow_bfs_augment_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   flow_req_type pending_reqs[$];
   flow_rsp_type expected_rsps[$];
   int mismatches = 0;
   int rsp_count = 0;
   int cycle_count = 0;

   // predictor state
   logic [mfba_pkg::NODE_W-1:0] cur_source, cur_sink;
   logic [mfba_pkg::NODE_W-1:0] mdl_head[ARCS];
   longint mdl_cap[ARCS];
   longint mdl_flow[ARCS];
   int mdl_next[ARCS];
   int mdl_first[NODES];
   int mdl_count;
   bit bfs_seen[NODES];
   int bfs_parent[NODES];
   int bfs_fifo[NODES];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void graph_clear();
      mdl_count = 0;
      for (int i = 0; i < NODES; i++) mdl_first[i] = NO_ARC;
   endfunction

   function automatic void graph_link(logic [mfba_pkg::NODE_W-1:0] tail,
                                      logic [mfba_pkg::NODE_W-1:0] head,
                                      logic [mfba_pkg::FCAP_W-1:0] cap);
      mdl_head[mdl_count] = head;
      mdl_cap[mdl_count]  = longint'(cap);
      mdl_flow[mdl_count] = 0;
      mdl_next[mdl_count] = mdl_first[tail];
      mdl_first[tail]     = mdl_count;
      mdl_count++;
   endfunction

   // one BFS plus augmentation, returns amount pushed
   function automatic longint augment_path(int s, int t);
      int qh, qt, u, a, v;
      bit found;
      longint best;
      qh = 0;
      qt = 0;
      found = 0;
      for (int i = 0; i < NODES; i++) bfs_seen[i] = 0;
      bfs_seen[s] = 1;
      bfs_fifo[qt++] = s;
      while (qh < qt) begin
         u = bfs_fifo[qh++];
         if (u == t) begin
            found = 1;
            break;
         end
         a = mdl_first[u];
         while (a < mdl_count) begin
            v = int'(mdl_head[a]);
            if (!bfs_seen[v] && mdl_cap[a] - mdl_flow[a] > 0) begin
               bfs_seen[v] = 1;
               bfs_parent[v] = a;
               if (qt < NODES) bfs_fifo[qt++] = v;
            end
            a = mdl_next[a];
         end
      end
      if (!found || s == t) return 0;
      best = 64'h7FFFFFFFFFFFFFFF;
      for (u = t; u != s; u = int'(mdl_head[bfs_parent[u] ^ 1]))
         if (mdl_cap[bfs_parent[u]] - mdl_flow[bfs_parent[u]] < best)
            best = mdl_cap[bfs_parent[u]] - mdl_flow[bfs_parent[u]];
      for (u = t; u != s; u = int'(mdl_head[bfs_parent[u] ^ 1])) begin
         a = bfs_parent[u];
         mdl_flow[a] += best;
         mdl_flow[a ^ 1] -= best;
      end
      return best;
   endfunction

   function automatic flow_rsp_type predict_flow(flow_req_type r);
      flow_rsp_type o;
      longint total, got;
      o.status = mfba_pkg::STAT_OK;
      o.total_flow = '0;
      total = 0;
      case (r.command)
         mfba_pkg::CMD_CLEAR: graph_clear();
         mfba_pkg::CMD_ADD: begin
            if (mdl_count + 2 > ARCS) o.status = mfba_pkg::STAT_FULL;
            else begin
               graph_link(r.from_node, r.to_node, r.fwd_cap);
               graph_link(r.to_node, r.from_node, r.rev_cap);
            end
         end
         mfba_pkg::CMD_RUN: begin
            do begin
               got = augment_path(int'(cur_source), int'(cur_sink));
               total += got;
            end while (got != 0);
            if (total > 64'hFFFFFFFF) begin
               o.status = mfba_pkg::STAT_SAT;
               o.total_flow = 32'hFFFFFFFF;
            end else o.total_flow = total[31:0];
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch @%0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      flow_req_type r;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid) begin
            r.command   = req_bus.command;
            r.from_node = req_bus.from_node;
            r.to_node   = req_bus.to_node;
            r.fwd_cap   = req_bus.forward_capacity;
            r.rev_cap   = req_bus.reverse_capacity;
            expected_rsps = {expected_rsps, predict_flow(r)};
         end
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            req_bus.command          <= r.command;
            req_bus.from_node        <= r.from_node;
            req_bus.to_node          <= r.to_node;
            req_bus.forward_capacity <= r.fwd_cap;
            req_bus.reverse_capacity <= r.rev_cap;
            req_bus.valid            <= 1'b1;
            req_gap = pick_gap();
         end else req_bus.valid <= 1'b0;
      end
   end

   // response ready, with one long hold-off partway through
   int rsp_hold = 0;
   bit long_hold_done = 0;
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else begin
         if (!long_hold_done && rsp_count >= 350) begin
            long_hold_done = 1;
            rsp_hold = LONG_HOLD;
         end else if (rsp_hold == 0) rsp_hold = pick_gap();
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else rsp_bus.ready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      flow_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no transaction outstanding", 0, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", longint'(rsp_bus.status), longint'(want.status));
            if (rsp_bus.total_flow !== want.total_flow)
               report_mismatch("total_flow", longint'(rsp_bus.total_flow),
                               longint'(want.total_flow));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_MAX) begin
         $display("timeout");
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_write(input logic [mfba_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mfba_pkg::NODE_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == mfba_pkg::CSR_SOURCE) cur_source = val;
      else cur_sink = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_bus.valid);
   endtask

   function automatic void queue_req(logic [1:0] c, logic [mfba_pkg::NODE_W-1:0] f,
                                     logic [mfba_pkg::NODE_W-1:0] t,
                                     logic [mfba_pkg::FCAP_W-1:0] fc,
                                     logic [mfba_pkg::FCAP_W-1:0] rc);
      flow_req_type r;
      r.command = c;
      r.from_node = f;
      r.to_node = t;
      r.fwd_cap = fc;
      r.rev_cap = rc;
      pending_reqs = {pending_reqs, r};
   endfunction

   function automatic logic [mfba_pkg::FCAP_W-1:0] rand_cap();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return CAP_MAX;
      if (r == 1) return mfba_pkg::FCAP_W'($urandom_range(0, 15));
      return mfba_pkg::FCAP_W'($urandom());
   endfunction

   function automatic logic [mfba_pkg::NODE_W-1:0] rand_node();
      if ($urandom_range(0, 9) == 0) return mfba_pkg::NODE_W'($urandom());
      return mfba_pkg::NODE_W'($urandom_range(0, 7));
   endfunction

   initial begin
      int r;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.command = mfba_pkg::CMD_CLEAR;
      req_bus.from_node = '0;
      req_bus.to_node = '0;
      req_bus.forward_capacity = '0;
      req_bus.reverse_capacity = '0;
      rsp_bus.ready = 1'b0;
      cur_source = 1;
      cur_sink = 2;
      graph_clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, default source 1 / sink 2
      queue_req(mfba_pkg::CMD_UNUSED, 9'h1FF, 9'h1FF, CAP_MAX, CAP_MAX);
      queue_req(mfba_pkg::CMD_RUN, 0, 0, 0, 0);
      queue_req(mfba_pkg::CMD_ADD, 1, 2, CAP_MAX, CAP_MAX);
      queue_req(mfba_pkg::CMD_ADD, 1, 3, 0, 24'h5);
      queue_req(mfba_pkg::CMD_ADD, 3, 2, 24'h7, 0);
      queue_req(mfba_pkg::CMD_ADD, 9'h1FF, 0, 24'hAAAAAA, 24'h555555);
      queue_req(mfba_pkg::CMD_ADD, 2, 4, 24'h10, 24'h10);
      queue_req(mfba_pkg::CMD_ADD, 4, 1, 24'h3, 24'h0);
      queue_req(mfba_pkg::CMD_RUN, 0, 0, 0, 0);
      queue_req(mfba_pkg::CMD_RUN, 0, 0, 0, 0);
      queue_req(mfba_pkg::CMD_ADD, 1, 3, 24'h9, 24'h1);
      queue_req(mfba_pkg::CMD_RUN, 0, 0, 0, 0);
      queue_req(mfba_pkg::CMD_CLEAR, 9'h1FF, 9'h1FF, CAP_MAX, CAP_MAX);
      queue_req(mfba_pkg::CMD_RUN, 0, 0, 0, 0);
      drain();

      // saturation between extreme node numbers
      csr_write(mfba_pkg::CSR_SOURCE, 0);
      csr_write(mfba_pkg::CSR_SINK, 9'h1FF);
      for (int i = 0; i < 257; i++) queue_req(mfba_pkg::CMD_ADD, 0, 9'h1FF, CAP_MAX, 0);
      queue_req(mfba_pkg::CMD_RUN, 0, 0, 0, 0);
      drain();
      csr_write(mfba_pkg::CSR_SOURCE, 9'h1FF);
      queue_req(mfba_pkg::CMD_RUN, 0, 0, 0, 0);
      queue_req(mfba_pkg::CMD_CLEAR, 0, 0, 0, 0);
      drain();

      // random phases
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(mfba_pkg::CSR_SOURCE, mfba_pkg::NODE_W'($urandom_range(0, 7)));
         csr_write(mfba_pkg::CSR_SINK, mfba_pkg::NODE_W'($urandom_range(0, 7)));
         for (int i = 0; i < 80; i++) begin
            r = $urandom_range(0, 99);
            if (r < 68)
               queue_req(mfba_pkg::CMD_ADD, rand_node(), rand_node(), rand_cap(), rand_cap());
            else if (r < 88)
               queue_req(mfba_pkg::CMD_RUN, rand_node(), rand_node(), rand_cap(), rand_cap());
            else if (r < 94)
               queue_req(mfba_pkg::CMD_UNUSED, rand_node(), rand_node(), rand_cap(),
                         rand_cap());
            else
               queue_req(mfba_pkg::CMD_CLEAR, rand_node(), rand_node(), rand_cap(),
                         rand_cap());
         end
         queue_req(mfba_pkg::CMD_RUN, 0, 0, 0, 0);
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/mfba_pkg.sv
sv/mfba_ifs.sv
sv/mfba_arc_mem.sv
sv/mfba_node_mem.sv
sv/max_flow_bfs_augment_core.sv
sv/mfba_checker.sv
tb/sv/testbench.sv
